### rtl/core/fqg_pkg.sv
package fqg_pkg;

   localparam int DATA_W   = 32;
   localparam int ACC_W    = 48;
   localparam int NBITS_W  = 5;
   localparam int CSR_IDX_W = 4;
   localparam int LEVEL_W  = 17;
   localparam int DIV_W    = 34;
   localparam int DIVISOR_W = 33;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MIN    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MAX    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_NUM_BITS     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_NARROW_RANGE = CSR_IDX_W'(3);

   localparam logic signed [DATA_W-1:0] RANGE_MIN_RST = -32'sd393216;
   localparam logic signed [DATA_W-1:0] RANGE_MAX_RST = 32'sd393216;
   localparam logic [NBITS_W-1:0]       NUM_BITS_RST  = 5'd8;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_in;
      logic signed [DATA_W-1:0] grad_in;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quantized_out;
      logic signed [DATA_W-1:0] grad_out;
      logic signed [ACC_W-1:0]  below_sum;
      logic signed [ACC_W-1:0]  above_sum;
      logic                     sums_valid;
   } rsp_type;

   // derived quantizer settings, shared by front and back
   typedef struct packed {
      logic signed [DATA_W-1:0] step_size;
      logic [DATA_W-1:0]        inverse_step;
      logic signed [DATA_W-1:0] nudged_low;
      logic signed [DATA_W-1:0] nudged_high;
   } derived_type;

   // one classified word waiting for the back end
   typedef struct packed {
      logic [DATA_W-1:0]        shifted;
      logic signed [DATA_W-1:0] grad;
      logic                     below;
      logic                     above;
      logic                     last;
   } entry_type;

endpackage

### rtl/core/fqg_div.sv
module fqg_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [fqg_pkg::DIV_W-1:0]           dividend,
   input  logic [fqg_pkg::DIVISOR_W-1:0]       divisor,
   output logic                                done,
   output logic [fqg_pkg::DIV_W-1:0]           quotient
);

   localparam int CNT_W = $clog2(fqg_pkg::DIV_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [fqg_pkg::DIV_W:0]       rem_ff, rem_in;
   logic [fqg_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [fqg_pkg::DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [fqg_pkg::DIV_W:0]       rem_sh;

   // one restoring step a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff[fqg_pkg::DIV_W-1:0], quo_ff[fqg_pkg::DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {2'b00, dvs_ff}) begin
            rem_in = rem_sh - {2'b00, dvs_ff};
            quo_in = {quo_ff[fqg_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[fqg_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(fqg_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/core/fqg_derive.sv
module fqg_derive (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fqg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fqg_pkg::DATA_W-1:0]           csr_data,
   output logic                                 busy,
   output fqg_pkg::derived_type                 derived
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SETUP = 4'd1;
   localparam logic [3:0] ST_DIV_S = 4'd2;
   localparam logic [3:0] ST_MUL_L = 4'd3;
   localparam logic [3:0] ST_CMP   = 4'd4;
   localparam logic [3:0] ST_DIV_K = 4'd5;
   localparam logic [3:0] ST_MUL_LO = 4'd6;
   localparam logic [3:0] ST_MUL_HI = 4'd7;
   localparam logic [3:0] ST_SET_HI = 4'd8;
   localparam logic [3:0] ST_DIV_I = 4'd9;

   localparam int LW = fqg_pkg::LEVEL_W;
   localparam int DW = fqg_pkg::DATA_W;
   localparam int PW = LW + DW - 1;

   logic signed [DW-1:0]            range_min_ff, range_max_ff;
   logic [fqg_pkg::NBITS_W-1:0]     num_bits_ff;
   logic                            narrow_ff;
   logic                            start_ff, start_in;
   logic [3:0]                      state_ff, state_in;
   logic [LW-1:0]                   levels_ff, levels_in;
   logic [DW-2:0]                   s_ff, s_in;
   logic [DW:0]                     neg_ff, neg_in;
   logic [LW-1:0]                   k_ff, k_in;
   logic [PW-1:0]                   prod_ff;
   logic [LW-1:0]                   mul_a;
   fqg_pkg::derived_type            der_ff, der_in;

   logic                            csr_fire;
   logic [fqg_pkg::NBITS_W-1:0]     nb;
   logic signed [DW:0]              span;
   logic                            div_start;
   logic [fqg_pkg::DIV_W-1:0]       div_num;
   logic [fqg_pkg::DIVISOR_W-1:0]   div_den;
   logic                            div_done;
   logic [fqg_pkg::DIV_W-1:0]       div_q;

   assign busy      = start_ff || (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign csr_fire  = csr_valid && csr_ready;
   assign derived   = der_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= fqg_pkg::RANGE_MIN_RST;
         range_max_ff <= fqg_pkg::RANGE_MAX_RST;
         num_bits_ff  <= fqg_pkg::NUM_BITS_RST;
         narrow_ff    <= 1'b0;
      end else if (csr_fire) begin
         unique case (csr_index)
            fqg_pkg::REG_RANGE_MIN:    range_min_ff <= csr_data;
            fqg_pkg::REG_RANGE_MAX:    range_max_ff <= csr_data;
            fqg_pkg::REG_NUM_BITS:     num_bits_ff  <= csr_data[fqg_pkg::NBITS_W-1:0];
            fqg_pkg::REG_NARROW_RANGE: narrow_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (num_bits_ff < 5'd2)       nb = 5'd2;
      else if (num_bits_ff > 5'd16) nb = 5'd16;
      else                          nb = num_bits_ff;
      span = {range_max_ff[DW-1], range_max_ff} - {range_min_ff[DW-1], range_min_ff};
   end

   always_comb begin
      unique case (state_ff)
         ST_MUL_L:  mul_a = levels_ff;
         ST_MUL_LO: mul_a = k_ff;
         default:   mul_a = levels_ff - k_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(s_ff);
   end

   always_comb begin
      state_in  = state_ff;
      start_in  = start_ff;
      levels_in = levels_ff;
      s_in      = s_ff;
      neg_in    = neg_ff;
      k_in      = k_ff;
      der_in    = der_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      if (csr_fire && (csr_index == fqg_pkg::REG_RANGE_MIN ||
                       csr_index == fqg_pkg::REG_RANGE_MAX ||
                       csr_index == fqg_pkg::REG_NUM_BITS ||
                       csr_index == fqg_pkg::REG_NARROW_RANGE)) begin
         start_in = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start_ff) begin
               start_in  = 1'b0;
               levels_in = (LW'(1) << nb) - LW'(1) - LW'(narrow_ff);
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            neg_in = (DW+1)'(0) - {range_min_ff[DW-1], range_min_ff};
            if (span <= 0) begin
               der_in.step_size    = '0;
               der_in.inverse_step = '0;
               der_in.nudged_low   = range_min_ff;
               der_in.nudged_high  = range_min_ff;
               state_in            = ST_IDLE;
            end else begin
               div_start = 1'b1;
               div_num   = fqg_pkg::DIV_W'(span[DW-1:0]) + fqg_pkg::DIV_W'(levels_ff >> 1);
               div_den   = fqg_pkg::DIVISOR_W'(levels_ff);
               state_in  = ST_DIV_S;
            end
         end
         ST_DIV_S: begin
            if (div_done) begin
               if (div_q > fqg_pkg::DIV_W'({(DW-1){1'b1}})) s_in = {(DW-1){1'b1}};
               else                                         s_in = div_q[DW-2:0];
               if (div_q == '0) begin
                  der_in.step_size    = '0;
                  der_in.inverse_step = '0;
                  der_in.nudged_low   = range_min_ff;
                  der_in.nudged_high  = range_min_ff;
                  state_in            = ST_IDLE;
               end else if (!range_min_ff[DW-1]) begin
                  k_in     = '0;
                  state_in = ST_MUL_LO;
               end else begin
                  state_in = ST_MUL_L;
               end
            end
         end
         ST_MUL_L: state_in = ST_CMP;
         ST_CMP: begin
            if (PW'(neg_ff) >= prod_ff) begin
               k_in     = levels_ff;
               state_in = ST_MUL_LO;
            end else begin
               div_start = 1'b1;
               div_num   = fqg_pkg::DIV_W'({neg_ff, 1'b0}) + fqg_pkg::DIV_W'(s_ff);
               div_den   = fqg_pkg::DIVISOR_W'({s_ff, 1'b0});
               state_in  = ST_DIV_K;
            end
         end
         ST_DIV_K: begin
            if (div_done) begin
               k_in     = div_q[LW-1:0];
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: begin
            // product holds k*s here
            if (prod_ff > PW'({1'b1, {(DW-1){1'b0}}}))
               der_in.nudged_low = {1'b1, {(DW-1){1'b0}}};
            else
               der_in.nudged_low = DW'(0) - prod_ff[DW-1:0];
            state_in = ST_SET_HI;
         end
         ST_SET_HI: begin
            if (prod_ff > PW'({(DW-1){1'b1}}))
               der_in.nudged_high = {1'b0, {(DW-1){1'b1}}};
            else
               der_in.nudged_high = prod_ff[DW-1:0];
            der_in.step_size = {1'b0, s_ff};
            div_start = 1'b1;
            div_num   = fqg_pkg::DIV_W'({1'b1, {DW{1'b0}}}) + fqg_pkg::DIV_W'(s_ff >> 1);
            div_den   = fqg_pkg::DIVISOR_W'(s_ff);
            state_in  = ST_DIV_I;
         end
         ST_DIV_I: begin
            if (div_done) begin
               if (div_q[fqg_pkg::DIV_W-1:DW] != '0) der_in.inverse_step = '1;
               else                                  der_in.inverse_step = div_q[DW-1:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
      levels_ff <= levels_in;
      s_ff      <= s_in;
      neg_ff    <= neg_in;
      k_ff      <= k_in;
      der_ff    <= der_in;
   end

   fqg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

endmodule

### rtl/core/fqg_front.sv
module fqg_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fqg_pkg::req_type      req_data,
   input  logic                  busy,
   input  fqg_pkg::derived_type  derived,
   output logic                  q_valid,
   input  logic                  q_pop,
   output fqg_pkg::entry_type    q_entry
);

   localparam int PTR_W = $clog2(fqg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(fqg_pkg::QUEUE_DEPTH + 1);
   localparam int DW    = fqg_pkg::DATA_W;

   fqg_pkg::entry_type  mem_ff [fqg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ff, rd_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                push;
   logic                pop;
   logic signed [DW-1:0] clamped;
   logic [DW:0]         diff;
   fqg_pkg::entry_type  ent;

   assign req_ready = !busy && (cnt_ff != CNT_W'(fqg_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = cnt_ff != '0;
   assign pop       = q_pop && q_valid;
   assign q_entry   = mem_ff[rd_ff];

   // classify and clamp against the nudged bounds
   always_comb begin
      ent.below = req_data.value_in < derived.nudged_low;
      ent.above = !ent.below && (req_data.value_in > derived.nudged_high);
      if (ent.below)      clamped = derived.nudged_low;
      else if (ent.above) clamped = derived.nudged_high;
      else                clamped = req_data.value_in;
      diff = {clamped[DW-1], clamped} - {derived.nudged_low[DW-1], derived.nudged_low};
      ent.shifted = diff[DW-1:0];
      ent.grad    = req_data.grad_in;
      ent.last    = req_data.last;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + PTR_W'(1);
         if (pop)  rd_ff <= rd_ff + PTR_W'(1);
         if (push && !pop)      cnt_ff <= cnt_ff + CNT_W'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

endmodule

### rtl/core/fqg_back.sv
module fqg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  fqg_pkg::derived_type  derived,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  fqg_pkg::entry_type    q_entry,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fqg_pkg::rsp_type      rsp_data
);

   localparam int DW = fqg_pkg::DATA_W;
   localparam int AW = fqg_pkg::ACC_W;

   logic                      advance;
   logic signed [AW-1:0]      below_acc_ff, above_acc_ff;
   logic signed [AW-1:0]      below_new, above_new;
   logic signed [AW:0]        bsum, asum;

   logic                      a_valid_ff;
   logic [2*DW-1:0]           a_prod_ff;
   fqg_pkg::rsp_type          a_rsp_ff, a_rsp_in;
   logic                      b_valid_ff;
   logic [2*DW-1:0]           b_prod_ff;
   fqg_pkg::rsp_type          b_rsp_ff;
   logic                      c_valid_ff;
   fqg_pkg::rsp_type          c_rsp_ff, c_rsp_in;

   logic [2*DW:0]             rnd;
   logic [DW:0]               level;
   logic signed [2*DW+1:0]    qv;

   assign advance   = !c_valid_ff || rsp_ready;
   assign q_pop     = advance;
   assign rsp_valid = c_valid_ff;
   assign rsp_data  = c_rsp_ff;

   // saturating gradient sums
   always_comb begin
      bsum = {below_acc_ff[AW-1], below_acc_ff} + (AW+1)'(q_entry.grad);
      asum = {above_acc_ff[AW-1], above_acc_ff} + (AW+1)'(q_entry.grad);
      below_new = below_acc_ff;
      above_new = above_acc_ff;
      if (q_entry.below) begin
         if (bsum[AW] != bsum[AW-1]) below_new = {bsum[AW], {(AW-1){!bsum[AW]}}};
         else                        below_new = bsum[AW-1:0];
      end
      if (q_entry.above) begin
         if (asum[AW] != asum[AW-1]) above_new = {asum[AW], {(AW-1){!asum[AW]}}};
         else                        above_new = asum[AW-1:0];
      end
      a_rsp_in               = '0;
      a_rsp_in.grad_out      = (q_entry.below || q_entry.above) ? '0 : q_entry.grad;
      a_rsp_in.sums_valid    = q_entry.last;
      if (q_entry.last) begin
         a_rsp_in.below_sum = below_new;
         a_rsp_in.above_sum = above_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         below_acc_ff <= '0;
         above_acc_ff <= '0;
      end else if (advance && q_valid) begin
         below_acc_ff <= q_entry.last ? '0 : below_new;
         above_acc_ff <= q_entry.last ? '0 : above_new;
      end
   end

   always_comb begin
      rnd   = {1'b0, a_prod_ff} + (2*DW+1)'({1'b1, {(DW-1){1'b0}}});
      level = rnd[2*DW:DW];
      qv    = $signed({2'b00, b_prod_ff}) + (2*DW+2)'(derived.nudged_low);
      c_rsp_in = b_rsp_ff;
      if (qv > $signed((2*DW+2)'({1'b0, {(DW-1){1'b1}}})))
         c_rsp_in.quantized_out = {1'b0, {(DW-1){1'b1}}};
      else if (qv < $signed({{(DW+2){1'b1}}, 1'b1, {(DW-1){1'b0}}}))
         c_rsp_in.quantized_out = {1'b1, {(DW-1){1'b0}}};
      else
         c_rsp_in.quantized_out = qv[DW-1:0];
   end

   // three stages: level product, dequantise product, saturate to output
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= q_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      if (advance) begin
         a_prod_ff <= (2*DW)'(q_entry.shifted) * (2*DW)'(derived.inverse_step);
         a_rsp_ff  <= a_rsp_in;
         b_prod_ff <= (2*DW)'(level) * (2*DW)'(derived.step_size[DW-2:0]);
         b_rsp_ff  <= a_rsp_ff;
         c_rsp_ff  <= c_rsp_in;
      end
   end

endmodule

### rtl/core/fake_quant_with_gradient.sv
// Channel  Direction  Handshake              Word
// req      in         req_valid / req_ready  value_in, grad_in, last
// rsp      out        rsp_valid / rsp_ready  quantized_out, grad_out, sums, sums_valid
// csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One word a cycle in steady state, unless rsp stalls or a recomputation runs;
// a taken word passes through the queue and the back-end stages before rsp_valid
// rises. The back end runs three stages (level multiply, dequantise multiply,
// saturate) behind a two-word queue, and all stages stall together on rsp.
// Reset, and every register write, starts a recomputation of step, nudged bounds
// and inverse step on a shared bit-serial divider, with req_ready and csr_ready low.
module fake_quant_with_gradient (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fqg_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fqg_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fqg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fqg_pkg::DATA_W-1:0]        csr_data
);

   logic                 busy;
   fqg_pkg::derived_type derived;
   logic                 q_valid;
   logic                 q_pop;
   fqg_pkg::entry_type   q_entry;

   // derive quantiser settings from the registers
   fqg_derive u_derive (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (busy),
      .derived   (derived)
   );

   // classify and clamp, then hold in the queue
   fqg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .busy      (busy),
      .derived   (derived),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_entry   (q_entry)
   );

   // quantise, dequantise and accumulate the out-of-range gradients
   fqg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .derived   (derived),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_entry   (q_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
